@@ sv/json_string_unescape_core_defines.svh @@
// Assertion macros shared by the checker files of the string unescape core.
// No dependencies; included by files that write concurrent assertions.
`ifndef JSON_STRING_UNESCAPE_CORE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define JSU_ASSERT_IMPLY(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("jsu check failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define JSU_ASSERT_NEXT(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("jsu check failed: next-cycle implication");

`endif

@@ sv/jsu_pkg.sv @@
// Types, constants and helper functions of the JSON string unescape core.
// No dependencies; used by the core, front, queue and back modules.
package jsu_pkg;

   // Default depth of the queue between front and back
   localparam int QueueDepthDefault = 4;

   // Source bytes with special meaning
   localparam logic [7:0] ByteQuote     = 8'h22;
   localparam logic [7:0] ByteBackslash = 8'h5c;
   localparam logic [7:0] ByteLowerU    = 8'h75;

   // Surrogate arithmetic
   localparam logic [15:0] HighUnitMin = 16'hd800;
   localparam logic [15:0] HighUnitMax = 16'hdbff;
   localparam logic [31:0] HighBase    = 32'h0000_d800;
   localparam logic [31:0] LowBase     = 32'h0000_dc00;
   localparam logic [31:0] SuppBase    = 32'h0001_0000;

   // Decoder modes
   typedef enum logic [2:0] {
      ModeNormal    = 3'd0,
      ModeEsc       = 3'd1,
      ModeHexHi     = 3'd2,
      ModeAfterHi   = 3'd3,
      ModeAfterHiBs = 3'd4,
      ModeHexLo     = 3'd5
   } jsu_mode_type;

   // One queued run: an optional code point to encode, then an optional byte
   typedef struct packed {
      logic        emit_cp;
      logic [31:0] cp;
      logic        emit_x;
      logic [7:0]  x;
      logic        fin;
      logic        unterm;
   } jsu_entry_type;

   // Hex digit value; anything else reads as zero
   function automatic logic [3:0] nibble(input logic [7:0] c);
      logic [3:0] n;
      n = 4'h0;
      if (c >= 8'h30 && c <= 8'h39) n = c[3:0];
      else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
         n = c[3:0] + 4'd9;
      return n;
   endfunction

   // Named escapes; other bytes pass through
   function automatic logic [7:0] escape_map(input logic [7:0] e);
      logic [7:0] m;
      m = e;
      case (e)
         8'h62:   m = 8'h08;
         8'h66:   m = 8'h0c;
         8'h6e:   m = 8'h0a;
         8'h72:   m = 8'h0d;
         8'h74:   m = 8'h09;
         default: m = e;
      endcase
      return m;
   endfunction

   // Surrogate pair to code point, 32-bit wrapping, low unit unchecked
   function automatic logic [31:0] combine(input logic [15:0] hi, input logic [15:0] lo);
      logic [31:0] hi_part;
      hi_part = ({16'h0000, hi} - HighBase) << 10;
      return SuppBase + hi_part + ({16'h0000, lo} - LowBase);
   endfunction

endpackage

@@ sv/jsu_req_if.sv @@
// Input channel: one raw string byte per transfer plus end-of-buffer mark.
// Depends on nothing beyond plain logic types.
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       end_of_buffer;

   modport source (output valid, output byte_value, output end_of_buffer, input ready);
   modport sink   (input valid, input byte_value, input end_of_buffer, output ready);
endinterface

@@ sv/jsu_rsp_if.sv @@
// Result channel: one decoded byte or end marker per transfer.
// Depends on nothing beyond plain logic types.
interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic       string_done;
   logic       unterminated;
   logic       last_of_run;

   modport source (output valid, output out_byte, output has_byte, output string_done,
                   output unterminated, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input has_byte, input string_done,
                   input unterminated, input last_of_run, output ready);
endinterface

@@ sv/json_string_unescape_core.sv @@
// Each byte's run is written to the run queue, then loaded into the back
// part's current-run register, which drives the result. Throughput: one
// source byte per cycle while each byte yields at most one result and the
// result channel is ready; a byte with N results (N up to 4) holds the
// encoder for N transfers, which the QueueDepth-entry queue absorbs. Reset
// (synchronous, active high) sets plain byte mode, empties queue and output.
module json_string_unescape_core #(
   parameter int QueueDepth = jsu_pkg::QueueDepthDefault
) (
   input logic      clock,
   input logic      reset,
   jsu_req_if.sink   req_chan,
   jsu_rsp_if.source rsp_chan
);

   logic                   q_full, q_valid, push, pop;
   jsu_pkg::jsu_entry_type push_entry, head_entry;

   // Classify source bytes
   jsu_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_byte_value   (req_chan.byte_value),
      .req_end_of_buffer(req_chan.end_of_buffer),
      .req_ready        (req_chan.ready),
      .q_full           (q_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   // Decouple the two parts
   jsu_queue #(.Depth(QueueDepth)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .head_entry(head_entry),
      .q_valid   (q_valid),
      .q_full    (q_full)
   );

   // Encode and emit results
   jsu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .head_entry      (head_entry),
      .pop             (pop),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_out_byte    (rsp_chan.out_byte),
      .rsp_has_byte    (rsp_chan.has_byte),
      .rsp_string_done (rsp_chan.string_done),
      .rsp_unterminated(rsp_chan.unterminated),
      .rsp_last_of_run (rsp_chan.last_of_run)
   );

endmodule

@@ sv/jsu_front.sv @@
// Front part: accepts source bytes, tracks escape/hex/surrogate state and
// classifies each byte into one queued run. Depends on jsu_pkg.
module jsu_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [7:0]             req_byte_value,
   input  logic                   req_end_of_buffer,
   output logic                   req_ready,
   input  logic                   q_full,
   output logic                   push,
   output jsu_pkg::jsu_entry_type push_entry
);

   jsu_pkg::jsu_mode_type mode_ff, mode_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [15:0] acc_ff, acc_in;
   logic [15:0] high_ff, high_in;

   logic        accept;
   logic        eob;
   logic        is_quote, is_bs, is_u;
   logic        plain_mode;
   logic [7:0]  esc_byte;
   logic [15:0] hex_val;
   logic        hex_done, hi_pair;
   logic        fin, unterm;
   jsu_pkg::jsu_entry_type entry;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign eob       = req_end_of_buffer;

   // Byte classification shared by both control blocks
   assign is_quote   = req_byte_value == jsu_pkg::ByteQuote;
   assign is_bs      = req_byte_value == jsu_pkg::ByteBackslash;
   assign is_u       = req_byte_value == jsu_pkg::ByteLowerU;
   assign esc_byte   = jsu_pkg::escape_map(req_byte_value);
   assign hex_val    = {acc_ff[11:0], jsu_pkg::nibble(req_byte_value)};
   assign hex_done   = (cnt_ff == 2'd3) || eob;
   assign hi_pair    = (cnt_ff == 2'd3) && !eob &&
                       hex_val >= jsu_pkg::HighUnitMin && hex_val <= jsu_pkg::HighUnitMax;
   assign plain_mode = (mode_ff == jsu_pkg::ModeNormal) || (mode_ff == jsu_pkg::ModeAfterHi);

   // String end: a quote read as a plain byte, or the buffer end
   assign fin    = eob || (plain_mode && is_quote);
   assign unterm = eob && !(plain_mode && is_quote);

   // Next state
   always_comb begin
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      high_in = high_ff;
      if (accept) begin
         unique case (mode_ff) inside
            jsu_pkg::ModeEsc: begin
               if (is_u && !eob) begin
                  mode_in = jsu_pkg::ModeHexHi;
                  cnt_in  = 2'd0;
                  acc_in  = 16'h0000;
               end else begin
                  mode_in = jsu_pkg::ModeNormal;
               end
            end
            jsu_pkg::ModeHexHi, jsu_pkg::ModeHexLo: begin
               if (!hex_done) begin
                  acc_in = hex_val;
                  cnt_in = cnt_ff + 2'd1;
               end else begin
                  cnt_in = 2'd0;
                  acc_in = 16'h0000;
                  if (mode_ff == jsu_pkg::ModeHexHi && hi_pair) begin
                     high_in = hex_val;
                     mode_in = jsu_pkg::ModeAfterHi;
                  end else begin
                     mode_in = jsu_pkg::ModeNormal;
                  end
               end
            end
            jsu_pkg::ModeAfterHi: begin
               mode_in = (is_bs && !eob) ? jsu_pkg::ModeAfterHiBs : jsu_pkg::ModeNormal;
            end
            jsu_pkg::ModeAfterHiBs: begin
               if (is_u && !eob) begin
                  mode_in = jsu_pkg::ModeHexLo;
                  cnt_in  = 2'd0;
                  acc_in  = 16'h0000;
               end else begin
                  mode_in = jsu_pkg::ModeNormal;
               end
            end
            default: begin
               mode_in = (is_bs && !eob) ? jsu_pkg::ModeEsc : jsu_pkg::ModeNormal;
            end
         endcase
         if (fin) begin
            mode_in = jsu_pkg::ModeNormal;
            cnt_in  = 2'd0;
            acc_in  = 16'h0000;
         end
      end
   end

   // Run descriptor for this byte
   always_comb begin
      entry         = '0;
      entry.x       = req_byte_value;
      entry.fin     = fin;
      entry.unterm  = unterm;
      unique case (mode_ff)
         jsu_pkg::ModeEsc: begin
            if (is_u) begin
               entry.emit_cp = eob;
            end else begin
               entry.emit_x = 1'b1;
               entry.x      = esc_byte;
            end
         end
         jsu_pkg::ModeHexHi: begin
            entry.emit_cp = hex_done && !hi_pair;
            entry.cp      = {16'h0000, hex_val};
         end
         jsu_pkg::ModeHexLo: begin
            entry.emit_cp = hex_done;
            entry.cp      = jsu_pkg::combine(high_ff, hex_val);
         end
         jsu_pkg::ModeAfterHi: begin
            // lone high unit, then the byte read as plain text
            entry.emit_cp = !(is_bs && !eob);
            entry.cp      = {16'h0000, high_ff};
            entry.emit_x  = !(is_bs && !eob) && !is_quote;
         end
         jsu_pkg::ModeAfterHiBs: begin
            if (is_u) begin
               entry.emit_cp = eob;
               entry.cp      = jsu_pkg::combine(high_ff, 16'h0000);
            end else begin
               entry.emit_cp = 1'b1;
               entry.cp      = {16'h0000, high_ff};
               entry.emit_x  = 1'b1;
               entry.x       = esc_byte;
            end
         end
         default: begin
            entry.emit_x = !is_quote && !(is_bs && !eob);
         end
      endcase
   end

   assign push       = accept && (entry.emit_cp || entry.emit_x || entry.fin);
   assign push_entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= jsu_pkg::ModeNormal;
         cnt_ff  <= 2'd0;
         acc_ff  <= 16'h0000;
         high_ff <= 16'h0000;
      end else begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
         acc_ff  <= acc_in;
         high_ff <= high_in;
      end
   end

endmodule

@@ sv/jsu_queue.sv @@
// Short FIFO of run descriptors between front and back parts.
// Depends on jsu_pkg for the entry type.
module jsu_queue #(
   parameter int Depth = jsu_pkg::QueueDepthDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  jsu_pkg::jsu_entry_type push_entry,
   input  logic                   pop,
   output jsu_pkg::jsu_entry_type head_entry,
   output logic                   q_valid,
   output logic                   q_full
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   jsu_pkg::jsu_entry_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign q_valid    = count_ff != '0;
   assign q_full     = count_ff == CntW'(Depth);
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_push    = push && !q_full;
   assign do_pop     = pop && q_valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ sv/jsu_back.sv @@
// Back part: takes one run descriptor at a time, UTF-8 encodes the code
// point and emits one result per transfer. Depends on jsu_pkg.
module jsu_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  jsu_pkg::jsu_entry_type head_entry,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_has_byte,
   output logic                   rsp_string_done,
   output logic                   rsp_unterminated,
   output logic                   rsp_last_of_run
);

   jsu_pkg::jsu_entry_type cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [1:0] idx_ff, idx_in;

   logic [2:0] n_cp, n_bytes;
   logic [1:0] last_idx;
   logic       is_last, fire;
   logic [7:0] sel_byte;

   // Byte k of an n-byte UTF-8 sequence, each byte truncated to 8 bits
   function automatic logic [7:0] utf8_byte(input logic [31:0] cp, input logic [2:0] n,
                                            input logic [1:0] k);
      logic [7:0] b;
      b = cp[7:0];
      case (n)
         3'd2: b = (k == 2'd0) ? (8'hc0 | cp[13:6]) : {2'b10, cp[5:0]};
         3'd3: begin
            case (k)
               2'd0:    b = 8'he0 | cp[19:12];
               2'd1:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         3'd4: begin
            case (k)
               2'd0:    b = 8'hf0 | cp[25:18];
               2'd1:    b = {2'b10, cp[17:12]};
               2'd2:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         default: b = cp[7:0];
      endcase
      return b;
   endfunction

   // Sequence length of the current run
   always_comb begin
      if (!cur_ff.emit_cp)               n_cp = 3'd0;
      else if (cur_ff.cp <= 32'h0000_007f) n_cp = 3'd1;
      else if (cur_ff.cp <= 32'h0000_07ff) n_cp = 3'd2;
      else if (cur_ff.cp <= 32'h0000_ffff) n_cp = 3'd3;
      else                                 n_cp = 3'd4;
   end

   assign n_bytes  = n_cp + {2'b00, cur_ff.emit_x};
   assign last_idx = (n_bytes == 3'd0) ? 2'd0 : 2'(n_bytes - 3'd1);
   assign is_last  = idx_ff == last_idx;
   assign sel_byte = ({1'b0, idx_ff} < n_cp) ? utf8_byte(cur_ff.cp, n_cp, idx_ff) : cur_ff.x;

   // Result fields
   assign rsp_valid        = cur_valid_ff;
   assign rsp_has_byte     = n_bytes != 3'd0;
   assign rsp_out_byte     = rsp_has_byte ? sel_byte : 8'h00;
   assign rsp_last_of_run  = is_last;
   assign rsp_string_done  = is_last && cur_ff.fin;
   assign rsp_unterminated = is_last && cur_ff.fin && cur_ff.unterm;

   // Load the next run when idle or when the last result transfers
   assign fire = rsp_valid && rsp_ready;
   assign pop  = q_valid && (!cur_valid_ff || (fire && is_last));

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (pop) begin
         cur_in       = head_entry;
         cur_valid_in = 1'b1;
         idx_in       = 2'd0;
      end else if (fire) begin
         if (is_last) cur_valid_in = 1'b0;
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

@@ sv/jsu_checker.sv @@
// Port-level checks on the result channel of the string unescape core,
// bound to the top level. Depends on json_string_unescape_core_defines.svh.
`include "json_string_unescape_core_defines.svh"

module jsu_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_byte,
   input logic       has_byte,
   input logic       string_done,
   input logic       unterminated,
   input logic       last_of_run
);

   // A stalled result holds
   `JSU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(out_byte) && $stable(has_byte) && $stable(string_done) && $stable(unterminated) && $stable(last_of_run))

   // The string only ends on the final result of a byte
   `JSU_ASSERT_IMPLY(a_done_last, clock, reset, rsp_valid && string_done, last_of_run)

   // Buffer-end flag only comes with the end of the string
   `JSU_ASSERT_IMPLY(a_unterm_done, clock, reset, rsp_valid && unterminated, string_done)

   // An empty result is only an end marker and carries a zero byte
   `JSU_ASSERT_IMPLY(a_empty_end, clock, reset, rsp_valid && !has_byte, out_byte == 8'h00 && string_done)

endmodule

bind json_string_unescape_core jsu_checker u_jsu_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .out_byte    (rsp_chan.out_byte),
   .has_byte    (rsp_chan.has_byte),
   .string_done (rsp_chan.string_done),
   .unterminated(rsp_chan.unterminated),
   .last_of_run (rsp_chan.last_of_run)
);
